FILE: rtl/rde_pkg.sv
package rde_pkg;

   localparam int VALUE_BITS  = 31;
   localparam int RADIX_BITS  = 6;
   localparam int DIGIT_BITS  = 6;
   localparam int CHAR_BITS   = 7;
   localparam int IDX_BITS    = $clog2(VALUE_BITS);
   localparam int COUNT_BITS  = $clog2(VALUE_BITS + 1);

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
   localparam logic [DIGIT_BITS-1:0] DIGIT_LIMIT = DIGIT_BITS'(10);
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = CHAR_BITS'(48);
   localparam logic [CHAR_BITS-1:0]  LETTER_BASE = CHAR_BITS'(65);

   // out-of-range register values clamp to the nearest legal base
   function automatic logic [RADIX_BITS-1:0] effective_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] res;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = r;
      end
      return res;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] res;
      if (d < DIGIT_LIMIT) begin
         res = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         res = LETTER_BASE + CHAR_BITS'(d - DIGIT_LIMIT);
      end
      return res;
   endfunction

endpackage

FILE: rtl/rde_divider.sv
module rde_divider
   import rde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [RADIX_BITS-1:0] divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [DIGIT_BITS-1:0] remainder
);

   logic                  active_ff;
   logic                  done_ff;
   logic [COUNT_BITS-1:0] step_ff;
   logic [VALUE_BITS-1:0] quo_ff;
   logic [DIGIT_BITS-1:0] rem_ff;
   logic [RADIX_BITS-1:0] div_ff;

   logic [DIGIT_BITS:0]   rem_shift;
   logic                  fits;
   logic [DIGIT_BITS:0]   rem_in;

   // one restoring division step per cycle, quotient bits shift in from the right
   always_comb begin
      rem_shift = {rem_ff, quo_ff[VALUE_BITS-1]};
      fits      = rem_shift >= {1'b0, div_ff};
      rem_in    = fits ? (rem_shift - {1'b0, div_ff}) : rem_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            step_ff   <= COUNT_BITS'(VALUE_BITS);
         end else if (active_ff) begin
            step_ff <= step_ff - COUNT_BITS'(1);
            if (step_ff == COUNT_BITS'(1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (active_ff) begin
         quo_ff <= {quo_ff[VALUE_BITS-2:0], fits};
         rem_ff <= rem_in[DIGIT_BITS-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/radix_digit_emitter_top.sv
// channel   direction  handshake          payload
// req       in         req_valid/stall    req_value[30:0]
// rsp       out        rsp_valid/stall    rsp_digit_char[6:0], rsp_last
// csr       in         csr_valid/ready    csr_radix[5:0]
//
// each digit is one pass through the shared bit-serial divider; once all digits are
// stored, each is read from the digit store (ST_FETCH, ST_LOAD) and presented in ST_SEND.
// the response side waits in ST_SEND while rsp_stall is high.
// req_stall is high from acceptance until the last digit's transaction completes.
// reset puts radix back to 10 and the sequencer to idle; csr writes are always taken.
module radix_digit_emitter_top
   import rde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_BITS-1:0]  rsp_digit_char,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RADIX_BITS-1:0] csr_radix
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FETCH,
      ST_LOAD,
      ST_SEND
   } state_type;

   state_type             state_ff;
   logic                  start_ff;
   logic [RADIX_BITS-1:0] radix_ff;
   logic [VALUE_BITS-1:0] q_work_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [IDX_BITS-1:0]   rd_idx_ff;
   logic [DIGIT_BITS-1:0] rd_data_ff;
   logic                  rsp_valid_ff;
   logic [CHAR_BITS-1:0]  rsp_char_ff;
   logic                  rsp_last_ff;

   logic [DIGIT_BITS-1:0] digit_store [VALUE_BITS];

   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [DIGIT_BITS-1:0] div_remainder;
   logic                  req_take;
   logic                  final_digit;

   assign req_take    = req_valid && (state_ff == ST_IDLE);
   assign final_digit = (div_quotient == '0) || (count_ff == COUNT_BITS'(VALUE_BITS - 1));

   rde_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (q_work_ff),
      .divisor   (effective_radix(radix_ff)),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_valid) begin
         radix_ff <= csr_radix;
      end
   end

   // remainders land least significant first and are read back in reverse
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIVIDE && div_done) begin
         digit_store[count_ff[IDX_BITS-1:0]] <= div_remainder;
      end
      if (state_ff == ST_FETCH) begin
         rd_data_ff <= digit_store[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         q_work_ff    <= '0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_char_ff  <= '0;
         rsp_last_ff  <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  q_work_ff <= req_value;
                  count_ff  <= '0;
                  start_ff  <= 1'b1;
                  state_ff  <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  count_ff <= count_ff + COUNT_BITS'(1);
                  if (final_digit) begin
                     rd_idx_ff <= count_ff[IDX_BITS-1:0];
                     state_ff  <= ST_FETCH;
                  end else begin
                     q_work_ff <= div_quotient;
                     start_ff  <= 1'b1;
                  end
               end
            end
            ST_FETCH: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               rsp_valid_ff <= 1'b1;
               rsp_char_ff  <= digit_to_char(rd_data_ff);
               rsp_last_ff  <= (rd_idx_ff == '0);
               state_ff     <= ST_SEND;
            end
            ST_SEND: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     rd_idx_ff <= rd_idx_ff - IDX_BITS'(1);
                     state_ff  <= ST_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;
   assign csr_ready      = 1'b1;

endmodule
